// ===== rtl/core/adpalu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ARM data-processing ALU block.
// Holds the opcode codes, status codes and the structs shared between its modules.
// No dependencies.
package adpalu_pkg;

    localparam int unsigned XLEN   = 32;
    localparam int unsigned RIDX_W = 4;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_opcode;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [1:0] ST_PSR         = 2'd2;

    localparam logic [RIDX_W-1:0] PC_REG = 4'd15;

    // One accepted instruction.
    typedef struct packed {
        logic [3:0]  opcode;
        logic        set_flags;
        logic        is_immediate;
        logic [3:0]  dest_reg;
        logic [3:0]  first_reg;
        logic [11:0] operand2_field;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [31:0] result_value;
        logic        reg_written;
        logic [3:0]  dest_out;
        logic [3:0]  flags_after;
        logic [1:0]  status;
    } t_out_item;

    // Register file write port.
    typedef struct packed {
        logic              en;
        logic [RIDX_W-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

endpackage

// ===== rtl/core/adpalu_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the ARM data-processing ALU block.
// Field widths are written out here; this file does not import adpalu_pkg.
interface adpalu_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic        set_flags;
    logic        is_immediate;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic [11:0] operand2_field;

    modport source (
        output valid, opcode, set_flags, is_immediate, dest_reg, first_reg, operand2_field,
        input  ready
    );
    modport sink (
        input  valid, opcode, set_flags, is_immediate, dest_reg, first_reg, operand2_field,
        output ready
    );
endinterface

interface adpalu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        reg_written;
    logic [3:0]  dest_out;
    logic [3:0]  flags_after;
    logic [1:0]  status;

    modport source (
        output valid, result_value, reg_written, dest_out, flags_after, status,
        input  ready
    );
    modport sink (
        input  valid, result_value, reg_written, dest_out, flags_after, status,
        output ready
    );
endinterface

// ===== rtl/core/adpalu_regfile.sv =====
`timescale 1ns / 1ps
// 16 x 32 register file with three registered read ports and one write port.
// Two memory copies share each write; depends on adpalu_pkg.
module adpalu_regfile (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  adpalu_pkg::t_rf_wr           i_wr,
    input  logic                         i_rd_en,
    input  logic [adpalu_pkg::RIDX_W-1:0] i_addr_n,
    input  logic [adpalu_pkg::RIDX_W-1:0] i_addr_m,
    input  logic [adpalu_pkg::RIDX_W-1:0] i_addr_s,
    output logic [adpalu_pkg::XLEN-1:0]   o_data_n,
    output logic [adpalu_pkg::XLEN-1:0]   o_data_m,
    output logic [adpalu_pkg::XLEN-1:0]   o_data_s
);
    import adpalu_pkg::*;

    localparam int unsigned DEPTH = 1 << RIDX_W;

    logic [XLEN-1:0]  mem_a [DEPTH];
    logic [XLEN-1:0]  mem_b [DEPTH];
    logic [DEPTH-1:0] r_valid;

    logic [XLEN-1:0] r_raw_n, r_raw_m, r_raw_s, r_wdata;
    logic            r_hit_n, r_hit_m, r_hit_s;
    logic            r_vld_n, r_vld_m, r_vld_s;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_a[i_wr.addr] <= i_wr.data;
            mem_b[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_raw_n <= mem_a[i_addr_n];
            r_raw_m <= mem_a[i_addr_m];
            r_raw_s <= mem_b[i_addr_s];
            // A write landing on the same edge is not yet in the memory read.
            r_wdata <= i_wr.data;
            r_hit_n <= i_wr.en && (i_wr.addr == i_addr_n);
            r_hit_m <= i_wr.en && (i_wr.addr == i_addr_m);
            r_hit_s <= i_wr.en && (i_wr.addr == i_addr_s);
            r_vld_n <= r_valid[i_addr_n];
            r_vld_m <= r_valid[i_addr_m];
            r_vld_s <= r_valid[i_addr_s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Entries never written since reset read as zero.
    assign o_data_n = r_hit_n ? r_wdata : (r_vld_n ? r_raw_n : '0);
    assign o_data_m = r_hit_m ? r_wdata : (r_vld_m ? r_raw_m : '0);
    assign o_data_s = r_hit_s ? r_wdata : (r_vld_s ? r_raw_s : '0);

endmodule

// ===== rtl/core/adpalu_shifter.sv =====
`timescale 1ns / 1ps
// Operand two generation: rotated immediate or barrel-shifted register.
// Combinational; depends on adpalu_pkg.
module adpalu_shifter (
    input  logic                       i_is_immediate,
    input  logic [11:0]                i_field,
    input  logic [adpalu_pkg::XLEN-1:0] i_rm_val,
    input  logic [7:0]                 i_rs_amt,
    input  logic                       i_carry,
    output logic [adpalu_pkg::XLEN-1:0] o_operand
);
    import adpalu_pkg::*;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;

    logic [XLEN-1:0]   imm_val, fill, lsl_v, lsr_v, asr_v, sh_v;
    logic [2*XLEN-1:0] imm_w, ror_w;
    logic [4:0]        imm_rot, amt;
    logic              by_reg, big, zero_amt;

    always_comb begin
        imm_val  = {24'd0, i_field[7:0]};
        imm_rot  = {i_field[11:8], 1'b0};
        imm_w    = {imm_val, imm_val} >> imm_rot;

        by_reg   = i_field[4];
        amt      = by_reg ? i_rs_amt[4:0] : i_field[11:7];
        big      = by_reg && (i_rs_amt[7:5] != 3'd0);
        zero_amt = by_reg ? (i_rs_amt == 8'd0) : (i_field[11:7] == 5'd0);

        fill  = {XLEN{i_rm_val[XLEN-1]}};
        lsl_v = i_rm_val << amt;
        lsr_v = i_rm_val >> amt;
        asr_v = XLEN'($signed(i_rm_val) >>> amt);
        ror_w = {i_rm_val, i_rm_val} >> amt;

        // An immediate amount of zero encodes LSR/ASR #32 and RRX.
        case (i_field[6:5])
            SH_LSL:  sh_v = big ? '0 : lsl_v;
            SH_LSR:  sh_v = (big || (!by_reg && zero_amt)) ? '0 : lsr_v;
            SH_ASR:  sh_v = (big || (!by_reg && zero_amt)) ? fill : asr_v;
            default: sh_v = (!by_reg && zero_amt) ? {i_carry, i_rm_val[XLEN-1:1]}
                                                  : ror_w[XLEN-1:0];
        endcase
        if (by_reg && zero_amt) begin
            sh_v = i_rm_val;
        end

        o_operand = i_is_immediate ? imm_w[XLEN-1:0] : sh_v;
    end

endmodule

// ===== rtl/core/adpalu_exec.sv =====
`timescale 1ns / 1ps
// ALU operation, flag update, status decode and register write request.
// Combinational; depends on adpalu_pkg.
module adpalu_exec (
    input  logic [3:0]                   i_opcode,
    input  logic                         i_set_flags,
    input  logic [adpalu_pkg::RIDX_W-1:0] i_dest_reg,
    input  logic [adpalu_pkg::XLEN-1:0]   i_op_a,
    input  logic [adpalu_pkg::XLEN-1:0]   i_op_b,
    input  logic [3:0]                   i_flags,
    output adpalu_pkg::t_out_item        o_res,
    output adpalu_pkg::t_rf_wr           o_wr
);
    import adpalu_pkg::*;

    t_opcode         op;
    logic [1:0]      status;
    logic            s_eff, is_sub, is_arith, is_write;
    logic [XLEN-1:0] x, y, ysel, res, sum;
    logic [XLEN:0]   sum_w;
    logic            n_f, z_f, c_f, v_f;
    logic [3:0]      flags;

    always_comb begin
        op = t_opcode'(i_opcode);

        if (!i_set_flags && (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN)) begin
            status = ST_PSR;
        end else if (op == OP_ADC || op == OP_SBC || op == OP_RSC || op == OP_TST ||
                     op == OP_TEQ || op == OP_CMN) begin
            status = ST_UNSUPPORTED;
        end else begin
            status = ST_OK;
        end

        // Writing the PC leaves the flags alone, but CMP never writes.
        s_eff    = i_set_flags && !((i_dest_reg == PC_REG) && (op != OP_CMP));
        is_sub   = (op == OP_SUB) || (op == OP_RSB) || (op == OP_CMP);
        is_arith = is_sub || (op == OP_ADD);
        is_write = (op != OP_CMP);

        x     = (op == OP_RSB) ? i_op_b : i_op_a;
        y     = (op == OP_RSB) ? i_op_a : i_op_b;
        ysel  = is_sub ? ~y : y;
        sum_w = {1'b0, x} + {1'b0, ysel} + {{XLEN{1'b0}}, is_sub};
        sum   = sum_w[XLEN-1:0];

        case (op)
            OP_AND:  res = i_op_a & i_op_b;
            OP_EOR:  res = i_op_a ^ i_op_b;
            OP_SUB:  res = sum;
            OP_RSB:  res = sum;
            OP_ADD:  res = sum;
            OP_CMP:  res = sum;
            OP_ORR:  res = i_op_a | i_op_b;
            OP_MOV:  res = i_op_b;
            OP_BIC:  res = i_op_a & ~i_op_b;
            default: res = ~i_op_b;
        endcase

        n_f = res[XLEN-1];
        z_f = (res == '0);
        c_f = sum_w[XLEN];
        v_f = is_sub ? ((x[XLEN-1] ^ y[XLEN-1]) & (x[XLEN-1] ^ res[XLEN-1]))
                     : (~(x[XLEN-1] ^ y[XLEN-1]) & (x[XLEN-1] ^ res[XLEN-1]));

        if (!s_eff) begin
            flags = i_flags;
        end else if (is_arith) begin
            flags = {n_f, z_f, c_f, v_f};
        end else begin
            flags = {n_f, z_f, i_flags[1:0]};
        end

        if (status != ST_OK) begin
            o_res.result_value = '0;
            o_res.reg_written  = 1'b0;
            o_res.dest_out     = '0;
            o_res.flags_after  = i_flags;
            o_res.status       = status;
            o_wr.en            = 1'b0;
        end else begin
            o_res.result_value = res;
            o_res.reg_written  = is_write;
            o_res.dest_out     = is_write ? i_dest_reg : '0;
            o_res.flags_after  = flags;
            o_res.status       = ST_OK;
            o_wr.en            = is_write;
        end
        o_wr.addr = i_dest_reg;
        o_wr.data = res;
    end

endmodule

// ===== rtl/core/arm_data_processing_alu_unit.sv =====
`timescale 1ns / 1ps
// ARM data-processing execute unit: register file, NZCV flags, barrel shifter, ALU.
// Depends on adpalu_pkg, adpalu_if, adpalu_regfile, adpalu_shifter and adpalu_exec.
//
// Usage:
//   i_in carries one data-processing instruction per item; o_out carries one result
//   item per instruction, in order. Both are valid/ready channels; an item moves on
//   an edge where valid and ready are both high.
//   The result is registered: on acceptance the register operands are read into the
//   register file's read registers and the fields into the input register; the
//   shifter and ALU then work from these when the item advances, updating the register
//   file, the flags and the result register together.
//   Throughput is one item per cycle while o_out.ready is high. A following item
//   reads state its predecessor wrote on the same edge via the register file bypass.
//   When the receiver stalls, the result register holds and one more item may wait
//   in the input register; i_in.ready drops only when both are full.
//   Reset (i_rst_n low, synchronous) empties both stages, clears the flags and marks
//   every register as zero at once; no clearing pass is needed.
module arm_data_processing_alu_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    adpalu_in_if.sink          i_in,
    adpalu_out_if.source       o_out
);
    import adpalu_pkg::*;

    t_in_item        r_in;
    logic            r_in_valid;
    t_out_item       r_out;
    logic            r_out_valid;
    logic [3:0]      r_flags;

    logic            in_ready, accept, advance;
    logic [XLEN-1:0] rn_val, rm_val, rs_val, op_b;
    t_out_item       exec_res;
    t_rf_wr          exec_wr, rf_wr;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;
    assign accept   = i_in.valid && in_ready;

    assign rf_wr.en   = exec_wr.en && advance;
    assign rf_wr.addr = exec_wr.addr;
    assign rf_wr.data = exec_wr.data;

    adpalu_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (rf_wr),
        .i_rd_en  (accept),
        .i_addr_n (i_in.first_reg),
        .i_addr_m (i_in.operand2_field[3:0]),
        .i_addr_s (i_in.operand2_field[11:8]),
        .o_data_n (rn_val),
        .o_data_m (rm_val),
        .o_data_s (rs_val)
    );

    adpalu_shifter u_shifter (
        .i_is_immediate (r_in.is_immediate),
        .i_field        (r_in.operand2_field),
        .i_rm_val       (rm_val),
        .i_rs_amt       (rs_val[7:0]),
        .i_carry        (r_flags[1]),
        .o_operand      (op_b)
    );

    adpalu_exec u_exec (
        .i_opcode    (r_in.opcode),
        .i_set_flags (r_in.set_flags),
        .i_dest_reg  (r_in.dest_reg),
        .i_op_a      (rn_val),
        .i_op_b      (op_b),
        .i_flags     (r_flags),
        .o_res       (exec_res),
        .o_wr        (exec_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= exec_res.flags_after;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.opcode         <= i_in.opcode;
            r_in.set_flags      <= i_in.set_flags;
            r_in.is_immediate   <= i_in.is_immediate;
            r_in.dest_reg       <= i_in.dest_reg;
            r_in.first_reg      <= i_in.first_reg;
            r_in.operand2_field <= i_in.operand2_field;
        end
        if (advance) begin
            r_out <= exec_res;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out.result_value;
    assign o_out.reg_written  = r_out.reg_written;
    assign o_out.dest_out     = r_out.dest_out;
    assign o_out.flags_after  = r_out.flags_after;
    assign o_out.status       = r_out.status;

endmodule
